// ===== hw/rtl/imu_mab_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU moving average package
// Shared sizes, types and codes for the IMU moving average and gyro bias
// calibration block.
// ----------------------------------------------------------------------------
package imu_mab_pkg;

  // Boxcar window length, 2 to 64 samples.
  localparam int WINDOW      = 10;
  // Samples in one gyro calibration run, 1 to 65535.
  localparam int CAL_SAMPLES = 5000;

  localparam int NCHAN    = 6;
  localparam int NGYRO    = 3;
  localparam int SAMPLE_W = 16;

  // A window sum of full-scale samples needs log2(WINDOW) bits of growth.
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  // A calibration sum of CAL_SAMPLES full-scale outputs.
  localparam int ACC_W = SAMPLE_W + $clog2(CAL_SAMPLES);
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

  // Reciprocal of the window length, scaled by 2^SUM_W and rounded down.
  localparam logic [SUM_W-1:0] MEAN_RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW);
  localparam logic [SUM_W-1:0] WINDOW_V   = SUM_W'(WINDOW);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  typedef struct packed {
    logic load_mul;
    logic load_quo;
  } mean_en_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/imu_moving_average_bias_cal.sv =====
// ----------------------------------------------------------------------------
// IMU moving average with gyro bias calibration
// Boxcar average of three accelerometer and three gyro channels over a
// window of samples, with a gyro bias that a calibration run measures.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low. A sample item
// shifts its six readings into a row of WINDOW cells and produces one result
// holding the six window averages (truncated toward zero), with the gyro
// bias subtracted from the gyro averages; the item passes the running sum,
// the reciprocal multiply and the correction before its result sits in the
// output register. A start item clears the gyro biases, begins a calibration
// run of CAL_SAMPLES samples and produces no result. While the run is open
// the calibrating flag of each result is high and the gyro outputs are
// summed; the sample that closes the run already reports the flag low. The
// biases are then divided out by a divider that multiplies by the reciprocal
// of CAL_SAMPLES and corrects the estimate in one step, so at the close of
// every run the item behind the closing sample waits for the multiply,
// correction and bias load before it reaches the output stage; at every
// other time the rate is one item per clock when the output is not stalled,
// set by the running window sum that is updated once per item. Until WINDOW
// samples have been taken the averages include the reset zeros of the window.
module imu_moving_average_bias_cal (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  imu_mab_pkg::sample_t in_accel_x_raw,
  input  imu_mab_pkg::sample_t in_accel_y_raw,
  input  imu_mab_pkg::sample_t in_accel_z_raw,
  input  imu_mab_pkg::sample_t in_gyro_x_raw,
  input  imu_mab_pkg::sample_t in_gyro_y_raw,
  input  imu_mab_pkg::sample_t in_gyro_z_raw,

  output logic                 out_valid,
  input  logic                 out_stall,
  output imu_mab_pkg::sample_t out_accel_x_avg,
  output imu_mab_pkg::sample_t out_accel_y_avg,
  output imu_mab_pkg::sample_t out_accel_z_avg,
  output imu_mab_pkg::sample_t out_gyro_x_out,
  output imu_mab_pkg::sample_t out_gyro_y_out,
  output imu_mab_pkg::sample_t out_gyro_z_out,
  output logic                 out_calibrating
);
  import imu_mab_pkg::*;

  localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

  // --------------------------------------------------------------------------
  // Pipeline handshake. Each stage moves forward when the stage after it is
  // empty or moving too, so bubbles close up and a waiting result does not
  // keep new items out of the earlier stages.
  // --------------------------------------------------------------------------
  logic      v1_r, v2_r, v3_r;
  op_t       op1_r, op2_r, op3_r;
  op_t       in_op;
  logic      accept;
  logic      ready1, ready2, ready3;
  logic      load2, load3, load_out;
  logic      out_free;
  logic      div_busy;
  logic      div_done;
  logic      out_valid_r, out_valid_nxt;

  assign in_op    = op_t'(in_operation);
  assign out_free = !out_valid_r || !out_stall;
  // The output stage is held while the bias divider works, so the sample
  // after the close of a run sees the new biases.
  assign load_out = v3_r && out_free && !div_busy;
  assign ready3   = !v3_r || load_out;
  assign load3    = v2_r && ready3;
  assign ready2   = !v2_r || ready3;
  assign load2    = v1_r && ready2;
  assign ready1   = !v1_r || ready2;
  assign accept   = in_valid && ready1;
  assign in_stall = !ready1;

  // --------------------------------------------------------------------------
  // Window: a row of cells that shifts once per sample item. The oldest
  // reading falls off the end of the row and leaves the running sum.
  // --------------------------------------------------------------------------
  sample_t chain [WINDOW+1][NCHAN];
  logic    shift;

  assign shift = accept && (in_op == OP_SAMPLE);

  assign chain[0][0] = in_accel_x_raw;
  assign chain[0][1] = in_accel_y_raw;
  assign chain[0][2] = in_accel_z_raw;
  assign chain[0][3] = in_gyro_x_raw;
  assign chain[0][4] = in_gyro_y_raw;
  assign chain[0][5] = in_gyro_z_raw;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    imu_mab_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (shift),
      .d_i     (chain[k]),
      .q_o     (chain[k+1])
    );
  end

  // Running sums are the first pipeline stage: they change only when an item
  // is accepted, which needs stage one to be free to move on.
  sum_t sum_r [NCHAN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCHAN; c++) begin
        sum_r[c] <= '0;
      end
    end else if (shift) begin
      for (int c = 0; c < NCHAN; c++) begin
        sum_r[c] <= sum_r[c] + SUM_W'(chain[0][c]) - SUM_W'(chain[WINDOW][c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Division of each window sum by the window length, two stages.
  // --------------------------------------------------------------------------
  mean_en_t mean_en;
  sample_t  avg [NCHAN];

  assign mean_en.load_mul = load2;
  assign mean_en.load_quo = load3;

  for (genvar c = 0; c < NCHAN; c++) begin : g_mean
    imu_mab_mean u_mean (
      .clk   (clk),
      .en_i  (mean_en),
      .sum_i (sum_r[c]),
      .avg_o (avg[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept ? 1'b1 : (load2 ? 1'b0 : v1_r);
      v2_r        <= load2  ? 1'b1 : (load3 ? 1'b0 : v2_r);
      v3_r        <= load3  ? 1'b1 : (load_out ? 1'b0 : v3_r);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op1_r <= in_op;
    end
    if (load2) begin
      op2_r <= op1_r;
    end
    if (load3) begin
      op3_r <= op2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage and calibration. Biases are subtracted here, the gyro
  // outputs of a run are summed here, and a start item takes effect here, so
  // every item sees the calibration state left by the items before it.
  // --------------------------------------------------------------------------
  sample_t          bias_r [NGYRO];
  sample_t          bias_nxt [NGYRO];
  acc_t             acc_r [NGYRO];
  acc_t             acc_nxt [NGYRO];
  acc_t             acc_sum [NGYRO];
  sample_t          gyro_res [NGYRO];
  logic [CNT_W-1:0] cal_cnt_r, cal_cnt_nxt;
  logic             cal_active_r, cal_active_nxt;
  logic             div_start;
  logic             start_load;
  div_stat_t        div_stat [NGYRO];
  sample_t          div_quot [NGYRO];
  sample_t          out_acc_r [3];
  sample_t          out_gyr_r [NGYRO];
  logic             out_cal_r;

  assign start_load = load_out && (op3_r == OP_START);

  always_comb begin
    for (int g = 0; g < NGYRO; g++) begin
      gyro_res[g] = SAMPLE_W'(avg[3+g] - bias_r[g]);
      acc_sum[g]  = acc_r[g] + ACC_W'(gyro_res[g]);
      bias_nxt[g] = bias_r[g];
      acc_nxt[g]  = acc_r[g];
    end
    cal_cnt_nxt    = cal_cnt_r;
    cal_active_nxt = cal_active_r;
    div_start      = 1'b0;

    if (load_out) begin
      if (op3_r == OP_START) begin
        for (int g = 0; g < NGYRO; g++) begin
          bias_nxt[g] = '0;
          acc_nxt[g]  = '0;
        end
        cal_cnt_nxt    = '0;
        cal_active_nxt = 1'b1;
      end else if (cal_active_r) begin
        for (int g = 0; g < NGYRO; g++) begin
          acc_nxt[g] = acc_sum[g];
        end
        if (cal_cnt_r == CAL_LAST) begin
          // Closing sample: it still used the zero bias, and its sums go
          // straight to the divider.
          cal_active_nxt = 1'b0;
          cal_cnt_nxt    = '0;
          div_start      = 1'b1;
        end else begin
          cal_cnt_nxt = cal_cnt_r + CNT_W'(1);
        end
      end
    end

    for (int g = 0; g < NGYRO; g++) begin
      if (div_stat[g].done) begin
        bias_nxt[g] = div_quot[g];
      end
    end

    if (load_out && (op3_r == OP_SAMPLE)) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  for (genvar g = 0; g < NGYRO; g++) begin : g_div
    imu_mab_bias_div u_div (
      .clk        (clk),
      .rst_n      (rst_n),
      .start_i    (div_start),
      .dividend_i (acc_sum[g]),
      .stat_o     (div_stat[g]),
      .quot_o     (div_quot[g])
    );
  end

  // All three dividers run in lock step.
  assign div_busy = div_stat[0].busy || div_stat[1].busy || div_stat[2].busy;
  assign div_done = div_stat[0].done || div_stat[1].done || div_stat[2].done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NGYRO; g++) begin
        bias_r[g] <= '0;
        acc_r[g]  <= '0;
      end
      cal_cnt_r    <= '0;
      cal_active_r <= 1'b0;
    end else begin
      for (int g = 0; g < NGYRO; g++) begin
        bias_r[g] <= bias_nxt[g];
        acc_r[g]  <= acc_nxt[g];
      end
      cal_cnt_r    <= cal_cnt_nxt;
      cal_active_r <= cal_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && (op3_r == OP_SAMPLE)) begin
      for (int c = 0; c < 3; c++) begin
        out_acc_r[c] <= avg[c];
      end
      for (int g = 0; g < NGYRO; g++) begin
        out_gyr_r[g] <= gyro_res[g];
      end
      out_cal_r <= cal_active_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accel_x_avg = out_acc_r[0];
  assign out_accel_y_avg = out_acc_r[1];
  assign out_accel_z_avg = out_acc_r[2];
  assign out_gyro_x_out  = out_gyr_r[0];
  assign out_gyro_y_out  = out_gyr_r[1];
  assign out_gyro_z_out  = out_gyr_r[2];
  assign out_calibrating = out_cal_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A run is never open while its biases are still being divided out.
  a_no_run_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    !(cal_active_r && div_busy))
    else $error("calibration run open while bias divider busy");

  // The sample count of a run never reaches the run length.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CAL_LAST)
    else $error("calibration count beyond run length");

  // Biases change only when a start item clears them or the divider ends.
  a_bias_source: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) &&
     !$stable({bias_r[0], bias_r[1], bias_r[2]}))
    |-> $past(div_done || start_load))
    else $error("gyro bias changed without a start item or divider result");

  // A result appears only for a sample item leaving the last stage.
  a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && $rose(out_valid_r))
    |-> $past(load_out && (op3_r == OP_SAMPLE)))
    else $error("result produced without a sample item");

endmodule

// ===== hw/rtl/imu_mab_cell.sv =====
// ----------------------------------------------------------------------------
// IMU moving average window cell
// One slot of the sample window: holds one reading of every channel and
// passes it on to the next cell when a new sample comes in.
// ----------------------------------------------------------------------------
module imu_mab_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_i,
  input  imu_mab_pkg::sample_t d_i [imu_mab_pkg::NCHAN],
  output imu_mab_pkg::sample_t q_o [imu_mab_pkg::NCHAN]
);
  import imu_mab_pkg::*;

  sample_t slot_r [NCHAN];

  // The window starts out full of zeros, so the cell resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCHAN; c++) begin
        slot_r[c] <= '0;
      end
    end else if (shift_i) begin
      for (int c = 0; c < NCHAN; c++) begin
        slot_r[c] <= d_i[c];
      end
    end
  end

  assign q_o = slot_r;

endmodule

// ===== hw/rtl/imu_mab_mean.sv =====
// ----------------------------------------------------------------------------
// IMU moving average mean unit
// Divides one window sum by the window length, truncating toward zero, in
// two registered stages: reciprocal multiply, then a one-step correction.
// ----------------------------------------------------------------------------
module imu_mab_mean (
  input  logic                    clk,
  input  imu_mab_pkg::mean_en_t   en_i,
  input  imu_mab_pkg::sum_t       sum_i,
  output imu_mab_pkg::sample_t    avg_o
);
  import imu_mab_pkg::*;

  logic [SUM_W-1:0]   mag;
  logic [2*SUM_W-1:0] prod_r;
  logic [SUM_W-1:0]   mag_r;
  logic               neg_r;
  logic [SUM_W-1:0]   q_est;
  logic [SUM_W-1:0]   q_win;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   quo;
  sample_t            avg_r;

  assign mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

  // The estimate is never above the true quotient and at most one below it.
  assign q_est = prod_r[2*SUM_W-1:SUM_W];
  assign q_win = SUM_W'(q_est * WINDOW_V);
  assign rem   = mag_r - q_win;
  assign quo   = (rem >= WINDOW_V) ? q_est + SUM_W'(1) : q_est;

  always_ff @(posedge clk) begin
    if (en_i.load_mul) begin
      prod_r <= (2*SUM_W)'(mag) * (2*SUM_W)'(MEAN_RECIP);
      mag_r  <= mag;
      neg_r  <= sum_i[SUM_W-1];
    end
    if (en_i.load_quo) begin
      avg_r <= neg_r ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);
    end
  end

  assign avg_o = avg_r;

endmodule

// ===== hw/rtl/imu_mab_bias_div.sv =====
// ----------------------------------------------------------------------------
// IMU gyro bias divider
// Turns a calibration sum into a bias by multiplying with the reciprocal of
// the run length and correcting the estimate by one, truncating toward zero
// and wrapping to 16 bits.
// ----------------------------------------------------------------------------
module imu_mab_bias_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_i,
  input  imu_mab_pkg::acc_t      dividend_i,
  output imu_mab_pkg::div_stat_t stat_o,
  output imu_mab_pkg::sample_t   quot_o
);
  import imu_mab_pkg::*;

  // The quotient of a full-scale sum never needs more than SAMPLE_W + 1 bits.
  localparam int RECIP_W = SAMPLE_W + 1;
  localparam int PROD_W  = ACC_W + RECIP_W;
  // Reciprocal of the run length, scaled by 2^ACC_W and rounded down.
  localparam logic [RECIP_W-1:0] CAL_RECIP =
    RECIP_W'((64'd1 << ACC_W) / CAL_SAMPLES);
  localparam logic [ACC_W-1:0]   DIVISOR   = ACC_W'(CAL_SAMPLES);

  logic               busy_r, busy_nxt;
  logic               mul_r, mul_nxt;
  logic               fix_r, fix_nxt;
  logic               done_r, done_nxt;
  logic [ACC_W-1:0]   mag_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  sample_t            quot_r;

  logic [RECIP_W-1:0] q_est;
  logic [ACC_W-1:0]   rem;
  logic [RECIP_W-1:0] quo;

  // The estimate is never above the true quotient and at most one below it.
  assign q_est = prod_r[PROD_W-1:ACC_W];
  assign rem   = mag_r - ACC_W'(q_est * DIVISOR);
  assign quo   = (rem >= DIVISOR) ? q_est + RECIP_W'(1) : q_est;

  // Busy stays high through the cycle that presents the result, so the
  // caller sees the new quotient before anything else may proceed.
  always_comb begin
    busy_nxt = busy_r;
    mul_nxt  = 1'b0;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (start_i) begin
      busy_nxt = 1'b1;
      mul_nxt  = 1'b1;
    end else if (done_r) begin
      busy_nxt = 1'b0;
    end else begin
      fix_nxt  = mul_r;
      done_nxt = fix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      mul_r  <= mul_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      mag_r <= dividend_i[ACC_W-1] ? ACC_W'(-dividend_i) : ACC_W'(dividend_i);
      neg_r <= dividend_i[ACC_W-1];
    end
    if (mul_r) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(CAL_RECIP);
    end
    if (fix_r) begin
      quot_r <= neg_r ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);
    end
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign quot_o      = quot_r;

endmodule
